/* hdl/eul_pkg.sv */
// ----------------------------------------------------------------------------
// eul_pkg
// Shared types, constants and helper functions for the Euler angle to
// direction cosine matrix core.
// ----------------------------------------------------------------------------
package eul_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;

    localparam int PREP_STAGES   = 3;
    localparam int MERGE_STAGES  = 4;
    localparam int PIPE_STAGES   = PREP_STAGES + CORDIC_N + MERGE_STAGES;

    // angle reduction and conversion to a 32-bit binary angle
    localparam int FULL_CIRCLE   = 23040;
    localparam int THETA_MUL     = 186413;   // floor(2^23 / 45)
    localparam int THETA_REM     = 23;       // 2^23 - 45 * THETA_MUL
    localparam int THETA_BIAS    = 22;
    localparam int RECIP45       = 1491309;  // ceil(2^26 / 45)
    localparam int RECIP_SHIFT   = 26;

    localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

    localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;
    localparam int OUT_HALF      = (2 ** OUT_SHIFT) / 2;
    localparam int OUT_LIM       = 2 ** OUT_FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_dcm;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q2.30 to output format: round half up, saturate to +-1.0, keep 16 bits
    function automatic logic [15:0] to_out(input logic signed [33:0] q);
        logic signed [35:0] v;
        v = 36'(q);
        v = (v + 36'(OUT_HALF)) >>> OUT_SHIFT;
        if (v > 36'(OUT_LIM)) begin
            v = 36'(OUT_LIM);
        end else if (v < -36'(OUT_LIM)) begin
            v = -36'(OUT_LIM);
        end
        return v[15:0];
    endfunction

endpackage

/* hdl/eul_angle_prep.sv */
// ----------------------------------------------------------------------------
// eul_angle_prep
// Reduces one angle modulo 360 degrees, converts it to a binary angle and
// folds it into +-90 degrees. Three pipeline stages.
// ----------------------------------------------------------------------------
module eul_angle_prep (
    input  logic                                  i_clk,
    input  logic [eul_pkg::PREP_STAGES-1:0]       i_en,
    input  logic signed [15:0]                    i_angle,
    output logic signed [33:0]                    o_z,
    output logic                                  o_flip
);
    import eul_pkg::*;

    logic signed [16:0] w_a;
    logic signed [16:0] w_t;
    logic [14:0]        r_r;

    logic [31:0]        r_hi;
    logic [13:0]        r_q;
    logic [19:0]        w_v;
    logic [40:0]        w_vq;

    logic [31:0]        w_theta;
    logic               w_flip;
    logic signed [33:0] r_z;
    logic               r_flip;

    always_comb begin
        w_a = 17'(i_angle);
        w_t = w_a;
        if (w_a < 0) begin
            w_t = w_a + 17'(FULL_CIRCLE);
            if (w_t < 0) begin
                w_t = w_t + 17'(FULL_CIRCLE);
            end
        end else if (w_a >= 17'(FULL_CIRCLE)) begin
            w_t = w_a - 17'(FULL_CIRCLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_r <= w_t[14:0];
        end
    end

    // theta = r*floor(2^23/45) + floor((23r + 22)/45)
    assign w_v  = 20'(r_r) * 20'(THETA_REM) + 20'(THETA_BIAS);
    assign w_vq = 41'(w_v) * 41'(RECIP45);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_hi <= 32'(r_r) * 32'(THETA_MUL);
            r_q  <= w_vq[RECIP_SHIFT +: 14];
        end
    end

    assign w_theta = r_hi + 32'(r_q);
    assign w_flip  = w_theta[31] ^ w_theta[30];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_z    <= 34'($signed({w_theta[31] ^ w_flip, w_theta[30:0]}));
            r_flip <= w_flip;
        end
    end

    assign o_z    = r_z;
    assign o_flip = r_flip;

endmodule

/* hdl/eul_cordic_lane.sv */
// ----------------------------------------------------------------------------
// eul_cordic_lane
// Pipelined CORDIC rotation, one stage per iteration, giving the cosine and
// sine of one folded binary angle in Q2.30.
// ----------------------------------------------------------------------------
module eul_cordic_lane (
    input  logic                                  i_clk,
    input  logic [eul_pkg::CORDIC_N-1:0]          i_en,
    input  logic signed [33:0]                    i_z,
    input  logic                                  i_flip,
    output logic signed [31:0]                    o_cos,
    output logic signed [31:0]                    o_sin
);
    import eul_pkg::*;

    logic signed [33:0] r_x [CORDIC_N];
    logic signed [33:0] r_y [CORDIC_N];
    logic signed [33:0] r_z [CORDIC_N];
    logic               r_f [CORDIC_N];

    logic signed [33:0] w_x [CORDIC_N];
    logic signed [33:0] w_y [CORDIC_N];
    logic signed [33:0] w_z [CORDIC_N];
    logic               w_f [CORDIC_N];

    logic signed [33:0] w_cos;
    logic signed [33:0] w_sin;

    assign w_x[0] = CORDIC_X0;
    assign w_y[0] = '0;
    assign w_z[0] = i_z;
    assign w_f[0] = i_flip;

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
        if (i > 0) begin : g_link
            assign w_x[i] = r_x[i-1];
            assign w_y[i] = r_y[i-1];
            assign w_z[i] = r_z[i-1];
            assign w_f[i] = r_f[i-1];
        end

        logic signed [33:0] w_dx;
        logic signed [33:0] w_dy;
        logic signed [33:0] w_at;

        assign w_dx = w_y[i] >>> i;
        assign w_dy = w_x[i] >>> i;
        assign w_at = $signed({2'b00, atan_turn(i)});

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                if (!w_z[i][33]) begin
                    r_x[i] <= w_x[i] - w_dx;
                    r_y[i] <= w_y[i] + w_dy;
                    r_z[i] <= w_z[i] - w_at;
                end else begin
                    r_x[i] <= w_x[i] + w_dx;
                    r_y[i] <= w_y[i] - w_dy;
                    r_z[i] <= w_z[i] + w_at;
                end
                r_f[i] <= w_f[i];
            end
        end
    end

    assign w_cos = r_f[CORDIC_N-1] ? -r_x[CORDIC_N-1] : r_x[CORDIC_N-1];
    assign w_sin = r_f[CORDIC_N-1] ? -r_y[CORDIC_N-1] : r_y[CORDIC_N-1];
    assign o_cos = $signed(w_cos[31:0]);
    assign o_sin = $signed(w_sin[31:0]);

endmodule

/* hdl/eul_dcm_merge.sv */
// ----------------------------------------------------------------------------
// eul_dcm_merge
// Combines the three lanes' sine and cosine into the nine matrix entries:
// products, rounding, triple products, sums and output saturation.
// ----------------------------------------------------------------------------
module eul_dcm_merge (
    input  logic                                  i_clk,
    input  logic [eul_pkg::MERGE_STAGES-1:0]      i_en,
    input  logic signed [31:0]                    i_cx,
    input  logic signed [31:0]                    i_sx,
    input  logic signed [31:0]                    i_cy,
    input  logic signed [31:0]                    i_sy,
    input  logic signed [31:0]                    i_cz,
    input  logic signed [31:0]                    i_sz,
    output eul_pkg::t_dcm                         o_dcm
);
    import eul_pkg::*;

    function automatic logic signed [33:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return $signed(t[33:0]);
    endfunction

    function automatic logic signed [31:0] q32(input logic signed [33:0] q);
        return $signed(q[31:0]);
    endfunction

    // stage 1: pair products
    logic signed [63:0] r_p_czcx, r_p_szcx, r_p_sxcz, r_p_sxsz;
    logic signed [63:0] r_p_m00, r_p_m01, r_p_m12, r_p_m22;
    logic signed [31:0] r1_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p_czcx <= i_cz * i_cx;
            r_p_szcx <= i_sz * i_cx;
            r_p_sxcz <= i_sx * i_cz;
            r_p_sxsz <= i_sx * i_sz;
            r_p_m00  <= i_cz * i_cy;
            r_p_m01  <= i_cy * i_sz;
            r_p_m12  <= i_sx * i_cy;
            r_p_m22  <= i_cy * i_cx;
            r1_sy    <= i_sy;
        end
    end

    // stage 2: round to Q2.30
    logic signed [33:0] r2_czcx, r2_szcx, r2_sxcz, r2_sxsz;
    logic signed [33:0] r2_m00, r2_m01, r2_m12, r2_m22;
    logic signed [31:0] r2_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_czcx <= qround(r_p_czcx);
            r2_szcx <= qround(r_p_szcx);
            r2_sxcz <= qround(r_p_sxcz);
            r2_sxsz <= qround(r_p_sxsz);
            r2_m00  <= qround(r_p_m00);
            r2_m01  <= qround(r_p_m01);
            r2_m12  <= qround(r_p_m12);
            r2_m22  <= qround(r_p_m22);
            r2_sy   <= r1_sy;
        end
    end

    // stage 3: triple products with sin pitch
    logic signed [63:0] r_p_a, r_p_b, r_p_c, r_p_d;
    logic signed [33:0] r3_czcx, r3_szcx, r3_sxcz, r3_sxsz;
    logic signed [33:0] r3_m00, r3_m01, r3_m12, r3_m22, r3_nsy;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p_a   <= q32(r2_sxcz) * r2_sy;
            r_p_b   <= q32(r2_sxsz) * r2_sy;
            r_p_c   <= q32(r2_czcx) * r2_sy;
            r_p_d   <= q32(r2_szcx) * r2_sy;
            r3_czcx <= r2_czcx;
            r3_szcx <= r2_szcx;
            r3_sxcz <= r2_sxcz;
            r3_sxsz <= r2_sxsz;
            r3_m00  <= r2_m00;
            r3_m01  <= r2_m01;
            r3_m12  <= r2_m12;
            r3_m22  <= r2_m22;
            r3_nsy  <= -34'(r2_sy);
        end
    end

    // stage 4: sums, output rounding and saturation
    t_dcm r_out;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_out.m00 <= to_out(r3_m00);
            r_out.m01 <= to_out(r3_m01);
            r_out.m02 <= to_out(r3_nsy);
            r_out.m10 <= to_out(qround(r_p_a) - r3_szcx);
            r_out.m11 <= to_out(r3_czcx + qround(r_p_b));
            r_out.m12 <= to_out(r3_m12);
            r_out.m20 <= to_out(r3_sxsz + qround(r_p_c));
            r_out.m21 <= to_out(qround(r_p_d) - r3_sxcz);
            r_out.m22 <= to_out(r3_m22);
        end
    end

    assign o_dcm = r_out;

endmodule

/* hdl/euler_to_rotation_matrix_core.sv */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// Roll, pitch and yaw (1/64 degree units) to the ground-to-body direction
// cosine matrix, x-y-z sequence, Q1.14 entries saturated to +-1.0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one angle triple per request in
//   i_data; output channel o_valid/i_ready carries the nine entries in o_data.
//   A request is taken whenever i_valid and o_ready are high at a clock edge.
//   Requests pass through the angle reduction stages, then the CORDIC
//   stages, one per iteration in each of three lanes (roll, pitch, yaw),
//   then the product/merge stages. Throughput is one request per cycle
//   while the receiver keeps i_ready high.
//   When the receiver holds i_ready low, the result waits in the output
//   register while earlier stages keep filling any empty slots; o_ready drops
//   only once every stage holds a request.
//   Synchronous active-low reset empties the pipeline and drops any
//   requests in flight; only the valid bits are reset.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  eul_pkg::t_angles  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output eul_pkg::t_dcm     o_data
);
    import eul_pkg::*;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] w_en;

    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_en
        assign w_en[k] = !(&r_vld[PIPE_STAGES-1:k]) | i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[PIPE_STAGES-1];

    logic signed [33:0] w_z [3];
    logic               w_f [3];
    logic signed [31:0] w_c [3];
    logic signed [31:0] w_s [3];
    logic signed [15:0] w_ang [3];

    assign w_ang[0] = i_data.roll_angle;
    assign w_ang[1] = i_data.pitch_angle;
    assign w_ang[2] = i_data.yaw_angle;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        eul_angle_prep u_prep (
            .i_clk   (i_clk),
            .i_en    (w_en[0 +: PREP_STAGES]),
            .i_angle (w_ang[l]),
            .o_z     (w_z[l]),
            .o_flip  (w_f[l])
        );

        eul_cordic_lane u_cordic (
            .i_clk  (i_clk),
            .i_en   (w_en[PREP_STAGES +: CORDIC_N]),
            .i_z    (w_z[l]),
            .i_flip (w_f[l]),
            .o_cos  (w_c[l]),
            .o_sin  (w_s[l])
        );
    end

    eul_dcm_merge u_merge (
        .i_clk (i_clk),
        .i_en  (w_en[PREP_STAGES + CORDIC_N +: MERGE_STAGES]),
        .i_cx  (w_c[0]),
        .i_sx  (w_s[0]),
        .i_cy  (w_c[1]),
        .i_sy  (w_s[1]),
        .i_cz  (w_c[2]),
        .i_sz  (w_s[2]),
        .o_dcm (o_data)
    );

endmodule

/* dv/tb_euler_to_rotation_matrix_core.sv */
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix_core
// Self-checking bench for the Euler angle to direction cosine matrix core.
// Angle triples are fed from a queue through a valid/ready driver. Each
// accepted request is run through a bit-exact fixed-point model: angle
// reduction, fold, CORDIC, Q2.30 products, rounding and saturation. A
// monitor checks each matrix against the oldest prediction. Both sides
// idle at random, the receiver holds off long enough to fill the pipeline,
// and the sender pauses now and then until the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix_core;

    import eul_pkg::*;

    localparam int     N_STAGES     = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int     FRAC         = OUT_FRAC_BITS;
    localparam int     DEG360       = 23040;
    localparam int     DEG90        = 5760;
    localparam longint GAIN_START   = 64'h26DD3B6A;
    localparam int     N_RANDOM     = 600;
    localparam int     DRAIN_CYCLES = 3 + N_STAGES + 4 + 20;
    localparam int     CYCLE_LIMIT  = 400000;

    typedef struct {
        t_angles angles;
        bit      drain_first;
    } t_pending;

    bit [31:0] atan_tbl [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_ready;
    t_angles i_data  = '0;
    logic    o_valid;
    logic    i_ready = 1'b0;
    t_dcm    o_data;

    t_pending pending_q [$];
    t_dcm     matrix_q  [$];
    t_pending next_req;
    t_dcm     want;

    int n_sent       = 0;
    int n_checked    = 0;
    int n_err        = 0;
    int n_backpress  = 0;
    int cycle_cnt    = 0;
    int tx_gap       = 0;
    int rx_hold      = 0;
    int roll_pick    = 0;
    bit long_hold_done = 1'b0;

    euler_to_rotation_matrix_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------
    function automatic void cordic_cos_sin(input logic signed [15:0] ang,
                                           output longint c, output longint s);
        int          r;
        int          i;
        logic [63:0] wide;
        logic [31:0] theta;
        bit          flip;
        longint      z, x, y, dx, dy;
        r = int'(ang) % DEG360;
        if (r < 0) r += DEG360;
        wide  = ((64'(r) << 23) + 64'd22) / 64'd45;
        theta = wide[31:0];
        flip  = (theta >= 32'h4000_0000) && (theta < 32'hC000_0000);
        if (flip) theta = theta - 32'h8000_0000;
        z = longint'($signed(theta));
        x = GAIN_START;
        y = 0;
        for (i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_tbl[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_tbl[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic [15:0] round_sat(input longint v);
        longint lim;
        longint q;
        lim = longint'(1) << FRAC;
        q   = v;
        if (FRAC < 30) q = (q + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
        if (q > lim) q = lim;
        else if (q < -lim) q = -lim;
        return q[15:0];
    endfunction

    function automatic t_dcm dcm_of(input t_angles a);
        longint cx, sx, cy, sy, cz, sz;
        longint czcx, szcx, sxcz, sxsz;
        t_dcm   m;
        cordic_cos_sin(a.roll_angle,  cx, sx);
        cordic_cos_sin(a.pitch_angle, cy, sy);
        cordic_cos_sin(a.yaw_angle,   cz, sz);
        czcx  = q30_mul(cz, cx);
        szcx  = q30_mul(sz, cx);
        sxcz  = q30_mul(sx, cz);
        sxsz  = q30_mul(sx, sz);
        m.m00 = round_sat(q30_mul(cz, cy));
        m.m01 = round_sat(q30_mul(cy, sz));
        m.m02 = round_sat(-sy);
        m.m10 = round_sat(-szcx + q30_mul(sxcz, sy));
        m.m11 = round_sat(czcx + q30_mul(sxsz, sy));
        m.m12 = round_sat(q30_mul(sx, cy));
        m.m20 = round_sat(sxsz + q30_mul(czcx, sy));
        m.m21 = round_sat(-sxcz + q30_mul(szcx, sy));
        m.m22 = round_sat(q30_mul(cy, cx));
        return m;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_request(input int roll, input int pitch, input int yaw,
                                        input bit drain_first);
        t_pending p;
        p.angles.roll_angle  = 16'(roll);
        p.angles.pitch_angle = 16'(pitch);
        p.angles.yaw_angle   = 16'(yaw);
        p.drain_first        = drain_first;
        pending_q.push_back(p);
    endfunction

    function automatic int random_angle();
        int r;
        r = $urandom_range(99);
        if (r < 70) return int'($urandom_range(2 * DEG360)) - DEG360;
        if (r < 82) return int'($urandom_range(65535));
        if (r < 94) return (int'($urandom_range(8)) - 4) * DEG90
                           + int'($urandom_range(4)) - 2;
        case ($urandom_range(4))
            0:       return -DEG360;
            1:       return DEG360;
            2:       return 32767;
            3:       return -32768;
            default: return 0;
        endcase
    endfunction

    function automatic int idle_len(input bit calm, input int short_max, input int long_min,
                                    input int long_max);
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(short_max, 1);
        return $urandom_range(long_max, long_min);
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && o_ready) begin
                matrix_q.push_back(dcm_of(i_data));
                n_sent <= n_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].drain_first || matrix_q.size() == 0)) begin
                    next_req = pending_q.pop_front();
                    i_data  <= next_req.angles;
                    i_valid <= 1'b1;
                    tx_gap  <= idle_len((n_sent >= 90 && n_sent < 260) ||
                                        (n_sent >= 400 && n_sent < 480), 3, 8, 40);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else if (!long_hold_done && n_sent >= 100) begin
            long_hold_done <= 1'b1;
            rx_hold        <= 150;
            i_ready        <= 1'b0;
        end else if (n_sent >= 400 && n_sent < 480) begin
            i_ready <= 1'b1;
        end else begin
            roll_pick = idle_len(1'b0, 3, 10, 40);
            rx_hold <= (roll_pick > 0) ? roll_pick - 1 : 0;
            i_ready <= (roll_pick == 0);
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    task automatic check_entry(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_ready) n_backpress <= n_backpress + 1;
            if (o_valid && i_ready) begin
                if (matrix_q.size() == 0) begin
                    $error("matrix delivered with no request outstanding");
                    n_err++;
                end else begin
                    want = matrix_q.pop_front();
                    check_entry("m00", want.m00, o_data.m00);
                    check_entry("m01", want.m01, o_data.m01);
                    check_entry("m02", want.m02, o_data.m02);
                    check_entry("m10", want.m10, o_data.m10);
                    check_entry("m11", want.m11, o_data.m11);
                    check_entry("m12", want.m12, o_data.m12);
                    check_entry("m20", want.m20, o_data.m20);
                    check_entry("m21", want.m21, o_data.m21);
                    check_entry("m22", want.m22, o_data.m22);
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // timeout
    // ------------------------------------------------------------------
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_euler_to_rotation_matrix_core: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        add_request(0, 0, 0, 1'b0);
        add_request(DEG90, 0, 0, 1'b0);
        add_request(0, DEG90, 0, 1'b0);
        add_request(0, 0, DEG90, 1'b0);
        add_request(-DEG90, -DEG90, -DEG90, 1'b0);
        add_request(2 * DEG90, 2 * DEG90, 2 * DEG90, 1'b0);
        add_request(-2 * DEG90, -2 * DEG90, -2 * DEG90, 1'b0);
        add_request(3 * DEG90, -3 * DEG90, 3 * DEG90, 1'b0);
        add_request(DEG360, -DEG360, DEG360, 1'b0);
        add_request(-DEG360, DEG360, -DEG360, 1'b0);
        add_request(32767, -32768, 32767, 1'b0);
        add_request(-32768, 32767, -32768, 1'b0);
        add_request(DEG90 - 1, DEG90 + 1, 3 * DEG90 - 1, 1'b0);
        add_request(3 * DEG90 + 1, -DEG90 + 1, -DEG90 - 1, 1'b0);
        add_request(2880, 2880, 2880, 1'b0);
        add_request(-2880, 8640, -14400, 1'b0);
        add_request(1, -1, 1, 1'b0);
        add_request(-1, 1, -1, 1'b0);
        add_request(16'h5555, 16'hAAAA, 16'h2AAA, 1'b0);
        add_request(16'hAAAA, 16'h5555, 16'hD555, 1'b0);
        add_request(2880, DEG90, 2880, 1'b0);
        add_request(-2880, -DEG90, 2880, 1'b0);
        add_request(DEG360 - 1, -DEG360 + 1, 16'h7F00, 1'b0);
        for (int k = 0; k < N_RANDOM; k++) begin
            add_request(random_angle(), random_angle(), random_angle(),
                        (k == 0) || (k == 480));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid || matrix_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d angle triples (quadrant edges, wraps, full 16-bit range)",
                 n_sent);
        $display("%0d matrices checked, input stalled %0d cycles by back-pressure",
                 n_checked, n_backpress);
        if (n_err == 0) begin
            $display("tb_euler_to_rotation_matrix_core: done, clean");
        end else begin
            $display("tb_euler_to_rotation_matrix_core: done, errors");
        end
        $finish;
    end

endmodule
